@@ rtl/core/egd_pkg.sv @@
package egd_pkg;

    localparam int unsigned BYTE_BITS   = 8;
    localparam int unsigned NBITS_W     = 4;
    localparam int unsigned COUNT_W     = 6;
    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned S_TDATA_W   = 16;
    localparam int unsigned M_TDATA_W   = 40;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TRUNC    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;      // take a new byte
        logic step;      // decode the next bit
        logic eos_step;  // end of stream handling
        logic flush;     // move the held result out as last of run
    } egd_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic bits_done;   // no stream bits left in the current byte
        logic bit_result;  // the current bit finishes a code or overflows
        logic eos_result;  // end of stream leaves a truncated code
        logic hold_valid;  // a result waits in the hold register
        logic out_free;    // output register can take a beat this cycle
    } egd_stat_t;

endpackage

@@ rtl/core/egd_ctrl.sv @@
module egd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  egd_pkg::egd_stat_t stat,
    output egd_pkg::egd_cmd_t  cmd
);
    import egd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BITS,
        S_EOS,
        S_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_BITS;
                end
            end
            S_BITS:
            begin
                if (stat.bits_done)
                begin
                    state_next = S_EOS;
                end
                else if (!(stat.bit_result && stat.hold_valid) || stat.out_free)
                begin
                    cmd.step = 1'b1;
                end
            end
            S_EOS:
            begin
                if (!(stat.eos_result && stat.hold_valid) || stat.out_free)
                begin
                    cmd.eos_step = 1'b1;
                    state_next   = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (!stat.hold_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

@@ rtl/core/egd_datapath.sv @@
module egd_datapath #(
    parameter int unsigned MAX_LEADING_ZEROS = 31
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  egd_pkg::egd_cmd_t              cmd,
    output egd_pkg::egd_stat_t             stat,
    input  logic [egd_pkg::BYTE_BITS-1:0]  in_byte,
    input  logic [egd_pkg::NBITS_W-1:0]    in_nbits,
    input  logic                           in_eos,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [egd_pkg::VALUE_W-1:0]    out_value,
    output logic [egd_pkg::STATUS_W-1:0]   out_status,
    output logic                           out_last
);
    import egd_pkg::*;

    localparam logic [COUNT_W-1:0] MAX_ZC = COUNT_W'(MAX_LEADING_ZEROS);

    // current byte
    logic [BYTE_BITS-1:0] byte_reg;
    logic [NBITS_W-1:0]   left_reg;
    logic                 eos_reg;
    logic [NBITS_W-1:0]   nbits_clamped;

    // decode state
    logic                 in_suffix_reg,    in_suffix_next;
    logic [COUNT_W-1:0]   zero_count_reg,   zero_count_next;
    logic [COUNT_W-1:0]   suffix_left_reg,  suffix_left_next;
    logic [VALUE_W-1:0]   suffix_value_reg, suffix_value_next;

    // one result held back until it is known whether it ends the run
    logic                 hold_valid_reg;
    logic [VALUE_W-1:0]   hold_value_reg;
    logic [STATUS_W-1:0]  hold_status_reg;

    logic                 out_valid_reg;
    logic [VALUE_W-1:0]   out_value_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic                 out_last_reg;

    logic                 bit_cur;
    logic [COUNT_W-1:0]   zc_inc;
    logic [COUNT_W-1:0]   sl_dec;
    logic [VALUE_W-1:0]   sv_shift;
    logic [VALUE_W-1:0]   prefix_mask;
    logic                 bit_res;
    logic [VALUE_W-1:0]   bit_value;
    logic [STATUS_W-1:0]  bit_status;
    logic                 eos_res;
    logic                 new_res;
    logic [VALUE_W-1:0]   new_value;
    logic [STATUS_W-1:0]  new_status;
    logic                 push_out;
    logic                 out_free;

    assign nbits_clamped = (in_nbits > NBITS_W'(BYTE_BITS)) ? NBITS_W'(BYTE_BITS) : in_nbits;

    assign bit_cur     = byte_reg[BYTE_BITS-1];
    assign zc_inc      = zero_count_reg + COUNT_W'(1);
    assign sl_dec      = suffix_left_reg - COUNT_W'(1);
    assign sv_shift    = {suffix_value_reg[VALUE_W-2:0], bit_cur};
    assign prefix_mask = ~({VALUE_W{1'b1}} << zero_count_reg[4:0]);

    // one bit of the code
    always_comb
    begin
        in_suffix_next    = in_suffix_reg;
        zero_count_next   = zero_count_reg;
        suffix_left_next  = suffix_left_reg;
        suffix_value_next = suffix_value_reg;
        bit_res           = 1'b0;
        bit_value         = '0;
        bit_status        = ST_OK;
        if (!in_suffix_reg)
        begin
            if (!bit_cur)
            begin
                if (zc_inc > MAX_ZC)
                begin
                    bit_res         = 1'b1;
                    bit_status      = ST_OVERFLOW;
                    zero_count_next = '0;
                end
                else
                begin
                    zero_count_next = zc_inc;
                end
            end
            else if (zero_count_reg == '0)
            begin
                bit_res = 1'b1;
            end
            else
            begin
                in_suffix_next    = 1'b1;
                suffix_left_next  = zero_count_reg;
                suffix_value_next = '0;
            end
        end
        else
        begin
            suffix_value_next = sv_shift;
            suffix_left_next  = sl_dec;
            if (sl_dec == '0)
            begin
                bit_res           = 1'b1;
                bit_value         = prefix_mask + sv_shift;
                in_suffix_next    = 1'b0;
                zero_count_next   = '0;
                suffix_left_next  = '0;
                suffix_value_next = '0;
            end
        end
    end

    assign eos_res    = eos_reg && (in_suffix_reg || (zero_count_reg != '0));
    assign new_res    = (cmd.step && bit_res) || (cmd.eos_step && eos_res);
    assign new_value  = cmd.step ? bit_value : '0;
    assign new_status = cmd.step ? bit_status : ST_TRUNC;
    assign push_out   = (new_res && hold_valid_reg) || cmd.flush;
    assign out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg         <= '0;
            eos_reg          <= 1'b0;
            in_suffix_reg    <= 1'b0;
            zero_count_reg   <= '0;
            suffix_left_reg  <= '0;
            suffix_value_reg <= '0;
            hold_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                left_reg <= nbits_clamped;
                eos_reg  <= in_eos;
            end
            else if (cmd.step)
            begin
                left_reg <= left_reg - NBITS_W'(1);
            end

            if (cmd.step)
            begin
                in_suffix_reg    <= in_suffix_next;
                zero_count_reg   <= zero_count_next;
                suffix_left_reg  <= suffix_left_next;
                suffix_value_reg <= suffix_value_next;
            end
            else if (cmd.eos_step && eos_reg)
            begin
                in_suffix_reg    <= 1'b0;
                zero_count_reg   <= '0;
                suffix_left_reg  <= '0;
                suffix_value_reg <= '0;
            end

            if (new_res)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                hold_valid_reg <= 1'b0;
            end

            if (push_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg <= in_byte;
        end
        else if (cmd.step)
        begin
            byte_reg <= {byte_reg[BYTE_BITS-2:0], 1'b0};
        end

        if (new_res)
        begin
            hold_value_reg  <= new_value;
            hold_status_reg <= new_status;
        end

        if (push_out)
        begin
            out_value_reg  <= hold_value_reg;
            out_status_reg <= hold_status_reg;
            out_last_reg   <= cmd.flush;
        end
    end

    assign stat.bits_done  = (left_reg == '0);
    assign stat.bit_result = bit_res;
    assign stat.eos_result = eos_res;
    assign stat.hold_valid = hold_valid_reg;
    assign stat.out_free   = out_free;

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

endmodule

@@ rtl/core/exp_golomb_ue_decoder.sv @@
// unsigned exp-golomb ue(v) decoder. each input beat carries one stream byte, decoded from
// bit 7 down, of which only the top valid_bits bits are used (values above eight count as
// eight, zero uses no bits); s_tlast marks the final byte of a stream. every finished code
// leaves one output beat with 2^n - 1 + suffix and status ok; a prefix longer than
// MAX_LEADING_ZEROS leaves status overflow with value zero and decoding restarts at the next
// bit; a code still open at the final byte leaves status truncated with value zero. m_tlast
// marks the last output beat caused by an input byte. bits are decoded one per clock, while
// the output side does not stall, by a single shared bit unit. after a byte is accepted the
// controller steps through its valid bits, sees that the byte is used up, takes the end of
// stream step and does the final flush, and only then accepts the next byte; it waits
// while the output side stalls. one result is held back inside so its last flag is known
// before it leaves.
module exp_golomb_ue_decoder #(
    parameter int unsigned MAX_LEADING_ZEROS = 31
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [egd_pkg::S_TDATA_W-1:0]  s_tdata,   // data_byte[7:0], valid_bits[11:8], zeros
    input  logic                           s_tlast,   // end_of_stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [egd_pkg::M_TDATA_W-1:0]  m_tdata,   // code_value[31:0], status[33:32], zeros
    output logic                           m_tlast    // last_of_run
);
    import egd_pkg::*;

    egd_cmd_t              cmd;
    egd_stat_t             stat;
    logic [VALUE_W-1:0]    code_value;
    logic [STATUS_W-1:0]   code_status;

    // sequencer: byte load, bit steps, end of stream, final flush
    egd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // bit decoder, hold register and output register
    egd_datapath #(
        .MAX_LEADING_ZEROS (MAX_LEADING_ZEROS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_byte    (s_tdata[BYTE_BITS-1:0]),
        .in_nbits   (s_tdata[BYTE_BITS+NBITS_W-1:BYTE_BITS]),
        .in_eos     (s_tlast),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_value  (code_value),
        .out_status (code_status),
        .out_last   (m_tlast)
    );

    // pack result fields, lowest bit first
    assign m_tdata = {{(M_TDATA_W-VALUE_W-STATUS_W){1'b0}}, code_status, code_value};

endmodule

@@ rtl/core/egd_checker.sv @@
module egd_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [egd_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                           m_tlast
);
    import egd_pkg::*;

    // stalled output beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // status is one of the three codes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[33:32] == ST_OK) || (m_tdata[33:32] == ST_TRUNC)
                     || (m_tdata[33:32] == ST_OVERFLOW))
        else $error("bad status code");

    // error results carry a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[33:32] != ST_OK) |-> (m_tdata[31:0] == '0))
        else $error("error result with nonzero value");

    // a decoded code never reaches all ones
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[33:32] == ST_OK) |-> (m_tdata[31:0] != 32'hFFFF_FFFF))
        else $error("code value out of range");

    // truncation is always the last result of its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[33:32] == ST_TRUNC) |-> m_tlast)
        else $error("truncated result not last of run");

endmodule

bind exp_golomb_ue_decoder egd_checker u_egd_checker (.*);
